// ===== rtl/core/mbrx_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package mbrx_pkg;

   localparam int BUFFER_BYTES_DEFAULT = 256;

   localparam logic [15:0] CRC_INIT = 16'hFFFF;
   localparam logic [15:0] CRC_POLY = 16'hA001;

   localparam logic [15:0] TIMEOUT_RESET = 16'd10;

   // configuration register indexes
   localparam logic CSR_EXPECTED_ADDRESS  = 1'b0;
   localparam logic CSR_INTERCHAR_TIMEOUT = 1'b1;

   typedef enum logic [1:0] {
      MODE_BYTE    = 2'd0,
      MODE_TICK    = 2'd1,
      MODE_RESTART = 2'd2
   } mode_type;

   localparam logic [2:0] ST_BUSY     = 3'd0;
   localparam logic [2:0] ST_GOOD     = 3'd1;
   localparam logic [2:0] ST_CRCERR   = 3'd2;
   localparam logic [2:0] ST_UNKNOWN  = 3'd3;
   localparam logic [2:0] ST_OVERFLOW = 3'd4;
   localparam logic [2:0] ST_TIMEOUT  = 3'd5;

   localparam logic [7:0] FC_READ_COILS    = 8'd1;
   localparam logic [7:0] FC_READ_HOLDING  = 8'd3;
   localparam logic [7:0] FC_READ_INPUT    = 8'd4;
   localparam logic [7:0] FC_WRITE_COIL    = 8'd5;
   localparam logic [7:0] FC_WRITE_REG     = 8'd6;
   localparam logic [7:0] FC_WRITE_MULTI   = 8'd16;

   typedef struct packed {
      logic [2:0]  status;
      logic [7:0]  function_code;
      logic [7:0]  byte_count;
      logic [8:0]  frame_length;
      logic [15:0] data_word;
      logic [15:0] crc_errors;
   } rsp_type;

   // one byte of crc-16, reflected, fully unrolled
   function automatic logic [15:0] crc_byte(input logic [15:0] crc_in, input logic [7:0] data);
      logic [15:0] crc;
      crc = crc_in ^ {8'h00, data};
      for (int k = 0; k < 8; k++) begin
         crc = crc[0] ? ((crc >> 1) ^ CRC_POLY) : (crc >> 1);
      end
      return crc;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/modbus_rtu_response_receiver.sv =====
// Modbus RTU master response receiver.
// req channel: one transaction per received event; req_mode selects a received
// byte (req_rx_byte), a timer tick or a restart before a new request.
// rsp channel: exactly one transaction per req transaction, in order, carrying
// status, the frame header fields, the data word and the running crc error count.
// csr port: expected slave address (index 0) and inter-character timeout in
// ticks (index 1); write only while no transaction is in flight.
// Order: an accepted request first loads the input register, then moves on into
// the result register once that register is free.
// Throughput: one transaction per cycle while rsp_ready is high; the crc update
// is one unrolled byte step between the two registers.
// When rsp_ready is low the result register holds and the input register can
// still take one more transaction before req_ready drops.
// Reset (synchronous) empties both registers, clears the frame index, silence
// timer and crc error count, and sets address 0 and timeout 10 ticks.
`timescale 1ns / 1ps
`default_nettype none

module modbus_rtu_response_receiver
   import mbrx_pkg::*;
#(
   parameter int BUFFER_BYTES = BUFFER_BYTES_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_write_data,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_mode,
   input  wire logic [7:0]  req_rx_byte,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [2:0]       rsp_status,
   output logic [7:0]       rsp_function_code,
   output logic [7:0]       rsp_byte_count,
   output logic [8:0]       rsp_frame_length,
   output logic [15:0]      rsp_data_word,
   output logic [15:0]      rsp_crc_errors
);

   logic       in_valid_ff;
   logic [1:0] in_mode_ff;
   logic [7:0] in_byte_ff;
   logic       out_valid_ff;
   rsp_type    out_ff;
   rsp_type    step_rsp;
   logic       step;

   // move the held transaction into the result register when it is free
   assign step      = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || step;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (step) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_ready && req_valid) begin
         in_mode_ff <= req_mode;
         in_byte_ff <= req_rx_byte;
      end
      if (step) begin
         out_ff <= step_rsp;
      end
   end

   mbrx_frame #(
      .BUFFER_BYTES(BUFFER_BYTES)
   ) u_frame (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .step_valid       (step),
      .step_mode        (in_mode_ff),
      .step_byte        (in_byte_ff),
      .step_rsp         (step_rsp)
   );

   assign rsp_valid         = out_valid_ff;
   assign rsp_status        = out_ff.status;
   assign rsp_function_code = out_ff.function_code;
   assign rsp_byte_count    = out_ff.byte_count;
   assign rsp_frame_length  = out_ff.frame_length;
   assign rsp_data_word     = out_ff.data_word;
   assign rsp_crc_errors    = out_ff.crc_errors;

endmodule

`default_nettype wire

// ===== rtl/core/mbrx_frame.sv =====
`timescale 1ns / 1ps
`default_nettype none

module mbrx_frame
   import mbrx_pkg::*;
#(
   parameter int BUFFER_BYTES = BUFFER_BYTES_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        csr_write_enable,
   input  wire logic        csr_index,
   input  wire logic [15:0] csr_write_data,
   input  wire logic        step_valid,
   input  wire logic [1:0]  step_mode,
   input  wire logic [7:0]  step_byte,
   output rsp_type          step_rsp
);

   localparam int IDX_W = $clog2(BUFFER_BYTES + 1);

   logic [7:0]       expected_address_ff;
   logic [15:0]      interchar_timeout_ff;

   logic [IDX_W-1:0] rx_index_ff, rx_index_in;
   logic [7:0]       header_ff [4];
   logic [7:0]       header_in [4];
   logic [15:0]      running_crc_ff, running_crc_in;
   logic [7:0]       last_two_ff [2];
   logic [7:0]       last_two_in [2];
   logic [15:0]      silence_count_ff, silence_count_in;
   logic             silence_timer_on_ff, silence_timer_on_in;
   logic [15:0]      crc_error_total_ff, crc_error_total_in;

   logic [IDX_W-1:0] next_pos;
   logic [9:0]       next_len;
   logic [15:0]      count_inc;
   logic [7:0]       fc;
   logic [7:0]       bc;
   logic             frame_done;
   rsp_type          rsp;

   always_ff @(posedge clock) begin
      if (reset) begin
         expected_address_ff  <= '0;
         interchar_timeout_ff <= TIMEOUT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_EXPECTED_ADDRESS:  expected_address_ff  <= csr_write_data[7:0];
            CSR_INTERCHAR_TIMEOUT: interchar_timeout_ff <= csr_write_data;
            default: ;
         endcase
      end
   end

   always_comb begin
      rx_index_in         = rx_index_ff;
      header_in           = header_ff;
      running_crc_in      = running_crc_ff;
      last_two_in         = last_two_ff;
      silence_count_in    = silence_count_ff;
      silence_timer_on_in = silence_timer_on_ff;
      crc_error_total_in  = crc_error_total_ff;
      next_pos            = rx_index_ff + IDX_W'(1);
      next_len            = 10'(next_pos);
      count_inc           = silence_count_ff + 16'd1;
      fc                  = 8'h00;
      bc                  = 8'h00;
      frame_done          = 1'b0;
      rsp                 = '0;

      unique case (mode_type'(step_mode))
         MODE_BYTE: begin
            silence_count_in    = '0;
            silence_timer_on_in = 1'b1;
            if (rx_index_ff == IDX_W'(BUFFER_BYTES)) begin
               rx_index_in         = '0;
               silence_timer_on_in = 1'b0;
               rsp.status          = ST_OVERFLOW;
            end else if (rx_index_ff != '0 || step_byte == expected_address_ff) begin
               if (rx_index_ff == '0) begin
                  running_crc_in = CRC_INIT;
               end else if (rx_index_ff != IDX_W'(1)) begin
                  running_crc_in = crc_byte(running_crc_ff, last_two_ff[0]);
               end
               last_two_in[0] = last_two_ff[1];
               last_two_in[1] = step_byte;
               if (rx_index_ff != '0 && rx_index_ff <= IDX_W'(4)) begin
                  header_in[2'(rx_index_ff - IDX_W'(1))] = step_byte;
               end
               rx_index_in = next_pos;

               if (next_len > 10'd3) begin
                  fc = header_in[0];
                  bc = header_in[1];
                  case (fc)
                     FC_READ_COILS, FC_READ_HOLDING, FC_READ_INPUT: begin
                        frame_done = next_len > (10'd4 + 10'(bc));
                     end
                     FC_WRITE_COIL, FC_WRITE_REG, FC_WRITE_MULTI: begin
                        frame_done = next_len > 10'd7;
                     end
                     default: begin
                        // unknown function, give up after the fourth byte
                        rx_index_in         = '0;
                        silence_timer_on_in = 1'b0;
                        rsp.status          = ST_UNKNOWN;
                        rsp.function_code   = fc;
                        rsp.byte_count      = bc;
                        rsp.frame_length    = 9'(next_pos);
                     end
                  endcase
                  if (frame_done) begin
                     rx_index_in         = '0;
                     silence_timer_on_in = 1'b0;
                     rsp.function_code   = fc;
                     rsp.byte_count      = bc;
                     rsp.frame_length    = 9'(next_pos);
                     // crc travels low byte first
                     if (running_crc_in == {last_two_in[1], last_two_in[0]}) begin
                        rsp.status    = ST_GOOD;
                        rsp.data_word = {header_in[2], header_in[3]};
                     end else begin
                        rsp.status         = ST_CRCERR;
                        crc_error_total_in = crc_error_total_ff + 16'd1;
                     end
                  end
               end
            end
         end
         MODE_TICK: begin
            if (silence_timer_on_ff) begin
               silence_count_in = count_inc;
               if (count_inc >= interchar_timeout_ff) begin
                  if (rx_index_ff != '0) begin
                     rsp.status = ST_TIMEOUT;
                  end
                  rx_index_in         = '0;
                  silence_timer_on_in = 1'b0;
                  silence_count_in    = '0;
               end
            end
         end
         MODE_RESTART: begin
            rx_index_in = '0;
         end
         default: ;
      endcase

      rsp.crc_errors = crc_error_total_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rx_index_ff         <= '0;
         running_crc_ff      <= CRC_INIT;
         silence_count_ff    <= '0;
         silence_timer_on_ff <= 1'b0;
         crc_error_total_ff  <= '0;
      end else if (step_valid) begin
         rx_index_ff         <= rx_index_in;
         running_crc_ff      <= running_crc_in;
         silence_count_ff    <= silence_count_in;
         silence_timer_on_ff <= silence_timer_on_in;
         crc_error_total_ff  <= crc_error_total_in;
      end
   end

   always_ff @(posedge clock) begin
      if (step_valid) begin
         header_ff   <= header_in;
         last_two_ff <= last_two_in;
      end
   end

   assign step_rsp = rsp;

   a_index_in_range: assert property (@(posedge clock) disable iff (reset)
      rx_index_ff <= IDX_W'(BUFFER_BYTES))
      else $error("receive index beyond buffer");

   a_idle_timer_clear: assert property (@(posedge clock) disable iff (reset)
      !silence_timer_on_ff |-> silence_count_ff == '0)
      else $error("silence count running with timer off");

   a_crc_error_counted: assert property (@(posedge clock) disable iff (reset)
      step_valid && rsp.status == ST_CRCERR
      |=> crc_error_total_ff == $past(crc_error_total_ff) + 16'd1)
      else $error("crc error not counted");

   a_frame_min_length: assert property (@(posedge clock) disable iff (reset)
      step_valid && (rsp.status == ST_GOOD || rsp.status == ST_CRCERR)
      |-> rsp.frame_length >= 9'd5 && rx_index_in == '0)
      else $error("completed frame too short or index not cleared");

endmodule

`default_nettype wire
